// ===== rtl/pbs_pkg.sv =====
// ----------------------------------------------------------------------------
// pbs_pkg
// Shared types for the planar byte shuffle: sequencer states, direction
// and register enums, the beat held in the output buffer, and read tags.
// ----------------------------------------------------------------------------
package pbs_pkg;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_SETUP,
    ST_EMIT
  } pbs_state_e;

  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } pbs_dir_e;

  typedef enum logic {
    REG_DIRECTION     = 1'b0,
    REG_WIDE_ELEMENTS = 1'b1
  } pbs_reg_e;

  // tag that follows a memory read until its registered read data arrives
  typedef struct packed {
    logic vld;
    logic last;
    logic ovf;
  } pbs_tag_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       ovf;
  } pbs_beat_t;

endpackage

// ===== rtl/pbs_in_if.sv =====
// ----------------------------------------------------------------------------
// pbs_in_if
// Input channel: one block byte per transfer, with an end-of-block mark.
// ----------------------------------------------------------------------------
interface pbs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       block_end;

  modport source (output valid, output data_byte, output block_end, input ready);
  modport sink   (input valid, input data_byte, input block_end, output ready);
endinterface

// ===== rtl/pbs_out_if.sv =====
// ----------------------------------------------------------------------------
// pbs_out_if
// Output channel: one rearranged byte per transfer with its block flags.
// ----------------------------------------------------------------------------
interface pbs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] shuffled_byte;
  logic       final_out;
  logic       overflowed;

  modport source (output valid, output shuffled_byte, output final_out,
                  output overflowed, input ready);
  modport sink   (input valid, input shuffled_byte, input final_out,
                  input overflowed, output ready);
endinterface

// ===== rtl/pbs_store.sv =====
// ----------------------------------------------------------------------------
// pbs_store
// Block store: single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module pbs_store #(
  parameter int MAX_BYTES = 64,
  parameter int ADDR_W    = $clog2(MAX_BYTES)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [7:0]        wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [7:0]        rdata_o
);

  logic [7:0] mem_q [MAX_BYTES];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/pbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// pbs_ctrl
// Sequencer: fills the store, then walks the transposed read order with
// plane/element counters and issues one read per cycle when credit allows.
// ----------------------------------------------------------------------------
module pbs_ctrl #(
  parameter int MAX_BYTES = 64,
  parameter int ADDR_W    = $clog2(MAX_BYTES),
  parameter int CNT_W     = $clog2(MAX_BYTES + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic              cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_byte_i,
  input  logic              in_end_i,
  output logic              we_o,
  output logic [ADDR_W-1:0] waddr_o,
  output logic [7:0]        wdata_o,
  output logic              re_o,
  output logic [ADDR_W-1:0] raddr_o,
  input  logic              can_issue_i,
  output pbs_pkg::pbs_tag_t tag_o
);

  pbs_pkg::pbs_state_e state_q, state_d;
  pbs_pkg::pbs_dir_e   dir_cfg_q, dir_q;
  logic                wide_cfg_q, wide_q;
  logic [CNT_W-1:0]    count_q, count_d;
  logic                ovf_q, ovf_d;
  logic [CNT_W-1:0]    elems_q, elems_d;
  logic [CNT_W-1:0]    elem_q, elem_d;
  logic [1:0]          plane_q, plane_d;
  logic [ADDR_W-1:0]   src_q, src_d;
  logic                in_xfer;
  logic                room;
  logic                issue;
  logic                last_rd;
  logic [1:0]          plane_max;
  logic [2:0]          esize;
  pbs_pkg::pbs_tag_t   tag_d, tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_cfg_q  <= pbs_pkg::DIR_DECODE;
      wide_cfg_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (pbs_pkg::pbs_reg_e'(cfg_idx_i))
        pbs_pkg::REG_DIRECTION:     dir_cfg_q  <= pbs_pkg::pbs_dir_e'(cfg_wdata_i);
        pbs_pkg::REG_WIDE_ELEMENTS: wide_cfg_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_xfer   = in_valid_i && in_ready_o;
  assign room      = count_q < CNT_W'(MAX_BYTES);
  assign plane_max = wide_q ? 2'd3 : 2'd1;
  assign esize     = wide_q ? 3'd4 : 3'd2;
  assign last_rd   = (plane_q == plane_max) && (elem_q == elems_q - CNT_W'(1));

  assign we_o    = in_xfer && room;
  assign waddr_o = count_q[ADDR_W-1:0];
  assign wdata_o = in_byte_i;
  assign re_o    = issue;
  assign raddr_o = src_q;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    ovf_d      = ovf_q;
    elems_d    = elems_q;
    elem_d     = elem_q;
    plane_d    = plane_q;
    src_d      = src_q;
    in_ready_o = 1'b0;
    issue      = 1'b0;
    tag_d      = '0;
    unique case (state_q)
      pbs_pkg::ST_FILL: begin
        in_ready_o = 1'b1;
        if (in_xfer) begin
          if (room) begin
            count_d = count_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_end_i) begin
            state_d = pbs_pkg::ST_SETUP;
          end
        end
      end
      pbs_pkg::ST_SETUP: begin
        elems_d = wide_q ? (count_q >> 2) : (count_q >> 1);
        elem_d  = '0;
        plane_d = '0;
        src_d   = '0;
        if (elems_d == '0) begin
          count_d = '0;
          ovf_d   = 1'b0;
          state_d = pbs_pkg::ST_FILL;
        end else begin
          state_d = pbs_pkg::ST_EMIT;
        end
      end
      pbs_pkg::ST_EMIT: begin
        issue = can_issue_i;
        if (issue) begin
          tag_d = '{vld: 1'b1, last: last_rd, ovf: ovf_q};
          if (dir_q == pbs_pkg::DIR_ENCODE) begin
            if (elem_q == elems_q - CNT_W'(1)) begin
              elem_d  = '0;
              plane_d = plane_q + 2'd1;
              src_d   = ADDR_W'(plane_q) + ADDR_W'(1);
            end else begin
              elem_d = elem_q + CNT_W'(1);
              src_d  = src_q + ADDR_W'(esize);
            end
          end else begin
            if (plane_q == plane_max) begin
              plane_d = '0;
              elem_d  = elem_q + CNT_W'(1);
              src_d   = elem_q[ADDR_W-1:0] + ADDR_W'(1);
            end else begin
              plane_d = plane_q + 2'd1;
              src_d   = src_q + elems_q[ADDR_W-1:0];
            end
          end
          if (last_rd) begin
            count_d = '0;
            ovf_d   = 1'b0;
            state_d = pbs_pkg::ST_FILL;
          end
        end
      end
      default: state_d = pbs_pkg::ST_FILL;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pbs_pkg::ST_FILL;
      count_q <= '0;
      ovf_q   <= 1'b0;
      tag_q   <= '0;
      dir_q   <= pbs_pkg::DIR_DECODE;
      wide_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      tag_q   <= tag_d;
      if (in_xfer && in_end_i) begin
        dir_q  <= dir_cfg_q;
        wide_q <= wide_cfg_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    elems_q <= elems_d;
    elem_q  <= elem_d;
    plane_q <= plane_d;
    src_q   <= src_d;
  end

  assign tag_o = tag_q;

endmodule

// ===== rtl/pbs_obuf.sv =====
// ----------------------------------------------------------------------------
// pbs_obuf
// Output register plus skid slot; grants read credit so no beat is lost.
// ----------------------------------------------------------------------------
module pbs_obuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pbs_pkg::pbs_tag_t tag_i,
  input  logic [7:0]        rdata_i,
  output logic              can_issue_o,
  output logic              valid_o,
  input  logic              ready_i,
  output pbs_pkg::pbs_beat_t beat_o
);

  logic               out_v_q, skid_v_q;
  pbs_pkg::pbs_beat_t out_q, skid_q, arr;
  logic               pop;
  logic [1:0]         occ;

  assign arr = '{data: rdata_i, last: tag_i.last, ovf: tag_i.ovf};
  assign pop = out_v_q && ready_i;
  assign occ = 2'(out_v_q) + 2'(skid_v_q) + 2'(tag_i.vld) - 2'(pop);
  assign can_issue_o = occ < 2'd2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (!out_v_q || pop) begin
        if (skid_v_q) begin
          out_v_q  <= 1'b1;
          skid_v_q <= tag_i.vld;
        end else begin
          out_v_q <= tag_i.vld;
        end
      end else if (tag_i.vld) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || pop) begin
      if (skid_v_q) begin
        out_q <= skid_q;
        if (tag_i.vld) begin
          skid_q <= arr;
        end
      end else if (tag_i.vld) begin
        out_q <= arr;
      end
    end else if (tag_i.vld) begin
      skid_q <= arr;
    end
  end

  assign valid_o = out_v_q;
  assign beat_o  = out_q;

endmodule

// ===== rtl/planar_byte_shuffle.sv =====
// ----------------------------------------------------------------------------
// planar_byte_shuffle
// Byte transpose of 2- or 4-byte elements between interleaved and planar
// order, buffered one block at a time in a single-port-pair memory.
// ----------------------------------------------------------------------------
// A block of n bytes is taken in one byte per cycle until the byte marked
// block_end; up to MAX_BYTES bytes are kept, the rest discarded and the block
// flagged overflowed. Direction and element size are captured with the
// block_end byte. A setup state follows, then E * floor(n / E) bytes leave
// at one per cycle, paced by the single read port of the block store and its
// registered read data, with an output register and skid slot absorbing
// back-pressure. Input is held off from the block_end transfer until the last
// store read is issued.
// ----------------------------------------------------------------------------
module planar_byte_shuffle #(
  parameter int MAX_BYTES = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_idx_i,
  input  logic      cfg_wdata_i,
  pbs_in_if.sink    in_if,
  pbs_out_if.source out_if
);

  localparam int ADDR_W = $clog2(MAX_BYTES);
  localparam int CNT_W  = $clog2(MAX_BYTES + 1);

  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic [7:0]         wdata;
  logic               re;
  logic [ADDR_W-1:0]  raddr;
  logic [7:0]         rdata;
  logic               can_issue;
  pbs_pkg::pbs_tag_t  tag;
  pbs_pkg::pbs_beat_t beat;

  pbs_ctrl #(
    .MAX_BYTES (MAX_BYTES),
    .ADDR_W    (ADDR_W),
    .CNT_W     (CNT_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .in_byte_i   (in_if.data_byte),
    .in_end_i    (in_if.block_end),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .re_o        (re),
    .raddr_o     (raddr),
    .can_issue_i (can_issue),
    .tag_o       (tag)
  );

  pbs_store #(
    .MAX_BYTES (MAX_BYTES),
    .ADDR_W    (ADDR_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  pbs_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tag_i       (tag),
    .rdata_i     (rdata),
    .can_issue_o (can_issue),
    .valid_o     (out_if.valid),
    .ready_i     (out_if.ready),
    .beat_o      (beat)
  );

  assign out_if.shuffled_byte = beat.data;
  assign out_if.final_out     = beat.last;
  assign out_if.overflowed    = beat.ovf;

endmodule

// ===== rtl/pbs_chk.sv =====
// ----------------------------------------------------------------------------
// pbs_chk
// Port-level checks for the planar byte shuffle, bound to the top level.
// ----------------------------------------------------------------------------
module pbs_chk (
  input logic       clk_i,
  input logic       rst_ni,
  pbs_in_if.sink    in_if,
  pbs_out_if.source out_if
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.shuffled_byte)
      && $stable(out_if.final_out) && $stable(out_if.overflowed))
    else $error("stalled result changed");

  // stop taking input right after the block end transfer
  a_end_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready && in_if.block_end |=> !in_if.ready)
    else $error("input taken right after block end");

  // keep filling after a byte that does not end the block
  a_fill_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready && !in_if.block_end |=> in_if.ready)
    else $error("input stalled in the middle of a block");

endmodule

bind planar_byte_shuffle pbs_chk u_pbs_chk (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_if  (in_if),
  .out_if (out_if)
);
